// ----- hw/rtl/kmcd_pkg.sv -----
package kmcd_pkg;

  localparam int unsigned MaxRowsDef = 8;
  localparam int unsigned MaxColsDef = 16;

  localparam int unsigned RowLevelW = 8;
  localparam int unsigned ColumnW   = 4;
  localparam int unsigned RowW      = 3;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 5;

  localparam logic [CfgIdxW-1:0] RegActiveLow = 2'd0;
  localparam logic [CfgIdxW-1:0] RegColsInUse = 2'd1;
  localparam logic [CfgIdxW-1:0] RegRowsInUse = 2'd2;

  localparam logic       ActiveLowRst = 1'b0;
  localparam logic [4:0] ColsInUseRst = 5'd16;
  localparam logic [3:0] RowsInUseRst = 4'd8;

  typedef struct packed {
    logic [RowLevelW-1:0] changed;
    logic [RowLevelW-1:0] asserted;
    logic [ColumnW-1:0]   column;
  } scan_load_t;

  typedef struct packed {
    logic              busy;
    logic              hit;
    logic [RowW-1:0]   row;
    logic [ColumnW-1:0] column;
    logic              down;
    logic              last;
  } scan_status_t;

endpackage

// ----- hw/rtl/kmcd_col_store.sv -----
module kmcd_col_store import kmcd_pkg::*; #(
  parameter int unsigned MAX_ROWS = MaxRowsDef,
  parameter int unsigned MAX_COLS = MaxColsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  logic [ColumnW-1:0]   column_i,
  input  logic [RowLevelW-1:0] wr_bits_i,
  output logic [RowLevelW-1:0] rd_bits_o
);

  localparam int unsigned RowsW = (MAX_ROWS < RowLevelW) ? MAX_ROWS : RowLevelW;
  localparam int unsigned Depth = (MAX_COLS < (1 << ColumnW)) ? MAX_COLS : (1 << ColumnW);
  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;

  logic [RowsW-1:0] bits_q [Depth];
  logic [IdxW-1:0]  idx;

  assign idx       = column_i[IdxW-1:0];
  assign rd_bits_o = RowLevelW'(bits_q[idx]);

  // all keys released after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        bits_q[i] <= '0;
      end
    end else if (wr_en_i) begin
      bits_q[idx] <= wr_bits_i[RowsW-1:0];
    end
  end

endmodule

// ----- hw/rtl/kmcd_row_scan.sv -----
module kmcd_row_scan import kmcd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  scan_load_t   load_data_i,
  input  logic         step_en_i,
  output scan_status_t status_o
);

  logic [RowLevelW-1:0] shift_q, shift_d;
  logic [RowLevelW-1:0] down_q, down_d;
  logic [RowW-1:0]      row_q, row_d;
  logic [ColumnW-1:0]   column_q, column_d;
  logic                 busy;

  assign busy = (shift_q != '0);

  always_comb begin
    shift_d  = shift_q;
    down_d   = down_q;
    row_d    = row_q;
    column_d = column_q;
    if (load_i) begin
      shift_d  = load_data_i.changed;
      down_d   = load_data_i.asserted;
      row_d    = '0;
      column_d = load_data_i.column;
    end else if (busy && (!shift_q[0] || step_en_i)) begin
      // one row per cycle, held while a hit waits for the output register
      shift_d = shift_q >> 1;
      down_d  = down_q >> 1;
      row_d   = row_q + RowW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
    end else begin
      shift_q <= shift_d;
    end
  end

  always_ff @(posedge clk_i) begin
    down_q   <= down_d;
    row_q    <= row_d;
    column_q <= column_d;
  end

  assign status_o.busy   = busy;
  assign status_o.hit    = shift_q[0];
  assign status_o.row    = row_q;
  assign status_o.column = column_q;
  assign status_o.down   = down_q[0];
  assign status_o.last   = (shift_q[RowLevelW-1:1] == '0);

endmodule

// ----- hw/rtl/key_matrix_change_detector.sv -----
// channel   direction  handshake                    payload
// in        input      in_valid_i / in_ready_o      scan_column_i, row_levels_i
// out       output     out_valid_o / out_ready_i    event_row_o, event_column_o,
//                                                   key_down_o, final_event_o
// cfg       input      cfg_we_i                     cfg_index_i, cfg_wdata_i
//
// a column transaction is accepted, then the row shifter scans one row per cycle, up to
// the highest changed row, holding on a changed row while the output is stalled
// an ignored column or one with no change leaves the shifter idle and in_ready_o high
// the shifter holds on a changed row while the output register is still full
// reset clears the column store to all released and loads register defaults
module key_matrix_change_detector import kmcd_pkg::*; #(
  parameter int unsigned MAX_ROWS = MaxRowsDef,
  parameter int unsigned MAX_COLS = MaxColsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [ColumnW-1:0]   scan_column_i,
  input  logic [RowLevelW-1:0] row_levels_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [RowW-1:0]      event_row_o,
  output logic [ColumnW-1:0]   event_column_o,
  output logic                 key_down_o,
  output logic                 final_event_o
);

  localparam int unsigned RowsW   = (MAX_ROWS < RowLevelW) ? MAX_ROWS : RowLevelW;
  localparam logic [3:0]  RowsLim = 4'(RowsW);
  localparam logic [6:0]  ColsLim = 7'(MAX_COLS);

  logic       active_low_q;
  logic [4:0] cols_in_use_q;
  logic [3:0] rows_in_use_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_low_q  <= ActiveLowRst;
      cols_in_use_q <= ColsInUseRst;
      rows_in_use_q <= RowsInUseRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegActiveLow: active_low_q  <= cfg_wdata_i[0];
        RegColsInUse: cols_in_use_q <= cfg_wdata_i[4:0];
        RegRowsInUse: rows_in_use_q <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  logic [3:0]           nrows;
  logic [RowLevelW-1:0] row_mask;
  logic [RowLevelW-1:0] asserted;
  logic [RowLevelW-1:0] prev_bits;
  logic                 col_ok;
  logic                 accept;
  logic                 load;
  logic                 out_free;
  scan_load_t           load_data;
  scan_status_t         st;

  assign nrows    = (rows_in_use_q < RowsLim) ? rows_in_use_q : RowsLim;
  assign row_mask = 8'hff >> (4'd8 - nrows);
  assign asserted = (active_low_q ? ~row_levels_i : row_levels_i) & row_mask;
  assign col_ok   = (5'(scan_column_i) < cols_in_use_q) && (7'(scan_column_i) < ColsLim);

  assign in_ready_o = !st.busy;
  assign accept     = in_valid_i && in_ready_o;
  assign load       = accept && col_ok;
  assign out_free   = !out_valid_o || out_ready_i;

  assign load_data.changed  = (prev_bits ^ asserted) & row_mask;
  assign load_data.asserted = asserted;
  assign load_data.column   = scan_column_i;

  kmcd_col_store #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (load),
    .column_i  (scan_column_i),
    .wr_bits_i (asserted),
    .rd_bits_o (prev_bits)
  );

  kmcd_row_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .load_data_i (load_data),
    .step_en_i   (out_free),
    .status_o    (st)
  );

  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (st.hit && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st.hit && out_free) begin
      event_row_o    <= st.row;
      event_column_o <= st.column;
      key_down_o     <= st.down;
      final_event_o  <= st.last;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
